// ===== hdl/frame_range_list_parser_assert.svh =====
// Assertion helpers shared by the frame range list parser.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef FRAME_RANGE_LIST_PARSER_ASSERT_SVH
`define FRAME_RANGE_LIST_PARSER_ASSERT_SVH

// Same-cycle implication.
`define FLP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FLP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/flp_pkg.sv =====
`timescale 1ns / 1ps

package flp_pkg;

    localparam int OUT_W    = 32;
    localparam int STATUS_W = 4;
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);

    // characters with a role of their own
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // status codes; zero doubles as "no error"
    localparam logic [STATUS_W-1:0] ST_PENDING       = 4'd0;
    localparam logic [STATUS_W-1:0] ST_OK            = 4'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY_LIST    = 4'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY_TOKEN   = 4'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY_VALUE   = 4'd4;
    localparam logic [STATUS_W-1:0] ST_INVALID       = 4'd5;
    localparam logic [STATUS_W-1:0] ST_RANGE         = 4'd6;
    localparam logic [STATUS_W-1:0] ST_EXTRA_DASH    = 4'd7;
    localparam logic [STATUS_W-1:0] ST_DESCENDING    = 4'd8;
    localparam logic [STATUS_W-1:0] ST_NOT_ASCENDING = 4'd9;

    typedef enum logic [2:0] {
        CLS_NONE  = 3'd0,
        CLS_BLANK = 3'd1,
        CLS_COMMA = 3'd2,
        CLS_DASH  = 3'd3,
        CLS_PLUS  = 3'd4,
        CLS_DIGIT = 3'd5,
        CLS_OTHER = 3'd6
    } char_class_t;

    typedef enum logic [4:0] {
        PH_LEAD   = 5'b00001,
        PH_PLUS   = 5'b00010,
        PH_DIGITS = 5'b00100,
        PH_TRAIL  = 5'b01000,
        PH_BAD    = 5'b10000
    } phase_t;

    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
        logic        last;
    } item_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    typedef struct packed {
        logic dash;
        logic extra;
        logic nonspace;
    } flags_t;

endpackage

// ===== hdl/flp_front.sv =====
`timescale 1ns / 1ps

module flp_front
(
    input  logic               tvalid,
    output logic               tready,
    input  logic [7:0]         ch,
    input  logic               has_char,
    input  logic               last,
    input  logic               q_full,
    output logic               push,
    output flp_pkg::item_t     push_item
);

    logic is_blank;

    assign tready = !q_full;
    assign push   = tvalid && !q_full;

    assign is_blank = (ch == flp_pkg::CH_SPACE)
                   || ((ch >= flp_pkg::CH_TAB) && (ch <= flp_pkg::CH_CR));

    always_comb
    begin
        push_item.last  = last;
        push_item.digit = 4'(ch - flp_pkg::CH_ZERO);
        if (!has_char)
        begin
            push_item.cls = flp_pkg::CLS_NONE;
        end
        else if (is_blank)
        begin
            push_item.cls = flp_pkg::CLS_BLANK;
        end
        else if (ch == flp_pkg::CH_COMMA)
        begin
            push_item.cls = flp_pkg::CLS_COMMA;
        end
        else if (ch == flp_pkg::CH_DASH)
        begin
            push_item.cls = flp_pkg::CLS_DASH;
        end
        else if (ch == flp_pkg::CH_PLUS)
        begin
            push_item.cls = flp_pkg::CLS_PLUS;
        end
        else if ((ch >= flp_pkg::CH_ZERO) && (ch <= flp_pkg::CH_NINE))
        begin
            push_item.cls = flp_pkg::CLS_DIGIT;
        end
        else
        begin
            push_item.cls = flp_pkg::CLS_OTHER;
        end
    end

endmodule

// ===== hdl/flp_queue.sv =====
`timescale 1ns / 1ps

module flp_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  flp_pkg::item_t     push_item,
    output logic               full,
    input  logic               pop,
    output flp_pkg::q_head_t   head
);

    localparam int CNT_W = flp_pkg::Q_PTR_W + 1;

    flp_pkg::item_t              mem [flp_pkg::Q_DEPTH];
    logic [flp_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [flp_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]            count_reg, count_next;

    assign full       = (count_reg == CNT_W'(flp_pkg::Q_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/flp_back.sv =====
`timescale 1ns / 1ps

module flp_back
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  flp_pkg::q_head_t              head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          range_valid,
    output logic [flp_pkg::OUT_W-1:0]     range_first,
    output logic [flp_pkg::OUT_W-1:0]     range_final,
    output logic                          list_done,
    output logic [flp_pkg::STATUS_W-1:0]  status
);

    localparam int VB    = VALUE_BITS;
    localparam int WIDE  = VB + 5;

    localparam logic [VB:0]     ACC_SAT  = {1'b1, {VB{1'b0}}};
    localparam logic [WIDE-1:0] WIDE_SAT = {4'b0000, 1'b1, {VB{1'b0}}};

    typedef struct packed {
        logic [flp_pkg::STATUS_W-1:0] err;
        logic [VB-1:0]                a;
        logic [VB-1:0]                b;
    } close_t;

    // parser state
    flp_pkg::phase_t              phase_reg, phase_next;
    logic [VB:0]                  acc_reg, acc_next;
    logic [VB-1:0]                first_reg, first_next;
    flp_pkg::flags_t              flags_reg, flags_next;
    logic [flp_pkg::STATUS_W-1:0] terr_reg, terr_next;
    logic [VB-1:0]                prev_reg, prev_next;
    logic                         have_prev_reg, have_prev_next;
    logic                         nonspace_reg, nonspace_next;
    logic [flp_pkg::STATUS_W-1:0] lerr_reg, lerr_next;

    // result register
    logic                          out_valid_reg, out_valid_next;
    logic                          rv_reg, rv_next;
    logic [flp_pkg::OUT_W-1:0]     first_out_reg, first_out_next;
    logic [flp_pkg::OUT_W-1:0]     final_out_reg, final_out_next;
    logic                          done_reg, done_next;
    logic [flp_pkg::STATUS_W-1:0]  status_reg, status_next;

    close_t                        cl_comma;
    close_t                        cl_end;
    logic                          emit;
    logic [VB-1:0]                 lo;
    logic [VB-1:0]                 hi;
    logic [WIDE-1:0]               wide;

    function automatic logic [flp_pkg::STATUS_W-1:0] part_code(flp_pkg::phase_t p,
                                                                logic [VB:0] acc);
        logic [flp_pkg::STATUS_W-1:0] r;
        unique case (p) inside
            flp_pkg::PH_LEAD:                  r = flp_pkg::ST_EMPTY_VALUE;
            flp_pkg::PH_PLUS, flp_pkg::PH_BAD: r = flp_pkg::ST_INVALID;
            default:                           r = acc[VB] ? flp_pkg::ST_RANGE
                                                           : flp_pkg::ST_PENDING;
        endcase
        return r;
    endfunction

    function automatic close_t close_token(flp_pkg::phase_t p, logic [VB:0] acc,
                                           logic [VB-1:0] fv, flp_pkg::flags_t f,
                                           logic [flp_pkg::STATUS_W-1:0] te,
                                           logic [VB-1:0] pf, logic hp);
        close_t                       r;
        logic [flp_pkg::STATUS_W-1:0] pc;
        pc    = part_code(p, acc);
        r.err = flp_pkg::ST_PENDING;
        r.a   = acc[VB-1:0];
        r.b   = acc[VB-1:0];
        if (!f.nonspace)
        begin
            r.err = flp_pkg::ST_EMPTY_TOKEN;
        end
        else if (f.extra)
        begin
            r.err = flp_pkg::ST_EXTRA_DASH;
        end
        else if (f.dash)
        begin
            r.a   = fv;
            r.err = (te != flp_pkg::ST_PENDING) ? te : pc;
            if ((r.err == flp_pkg::ST_PENDING) && (r.b < r.a))
            begin
                r.err = flp_pkg::ST_DESCENDING;
            end
        end
        else
        begin
            r.err = pc;
        end
        if ((r.err == flp_pkg::ST_PENDING) && hp && (r.a <= pf))
        begin
            r.err = flp_pkg::ST_NOT_ASCENDING;
        end
        return r;
    endfunction

    // zero-extend or truncate a value to the output width
    function automatic logic [flp_pkg::OUT_W-1:0] to_out(logic [VB-1:0] v);
        logic [VB+flp_pkg::OUT_W-1:0] t;
        t = {{flp_pkg::OUT_W{1'b0}}, v};
        return t[flp_pkg::OUT_W-1:0];
    endfunction

    assign pop       = head.valid && (!out_valid_reg || out_ready);
    assign cl_comma  = close_token(phase_reg, acc_reg, first_reg, flags_reg, terr_reg,
                                   prev_reg, have_prev_reg);
    assign wide      = ({4'b0000, acc_reg} << 3) + ({4'b0000, acc_reg} << 1)
                     + WIDE'(head.item.digit);

    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        first_next     = first_reg;
        flags_next     = flags_reg;
        terr_next      = terr_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        nonspace_next  = nonspace_reg;
        lerr_next      = lerr_reg;
        emit           = 1'b0;
        lo             = '0;
        hi             = '0;
        status_next    = flp_pkg::ST_PENDING;

        // character step
        if ((head.item.cls != flp_pkg::CLS_NONE) && (lerr_reg == flp_pkg::ST_PENDING))
        begin
            if (head.item.cls != flp_pkg::CLS_BLANK)
            begin
                nonspace_next = 1'b1;
            end
            if (head.item.cls == flp_pkg::CLS_COMMA)
            begin
                if (cl_comma.err == flp_pkg::ST_PENDING)
                begin
                    emit           = 1'b1;
                    lo             = cl_comma.a;
                    hi             = cl_comma.b;
                    prev_next      = cl_comma.b;
                    have_prev_next = 1'b1;
                end
                else
                begin
                    lerr_next = cl_comma.err;
                end
                phase_next = flp_pkg::PH_LEAD;
                acc_next   = '0;
                first_next = '0;
                flags_next = '0;
                terr_next  = flp_pkg::ST_PENDING;
            end
            else if (head.item.cls == flp_pkg::CLS_DASH)
            begin
                flags_next.nonspace = 1'b1;
                if (flags_reg.dash)
                begin
                    flags_next.extra = 1'b1;
                end
                else
                begin
                    terr_next       = part_code(phase_reg, acc_reg);
                    first_next      = acc_reg[VB-1:0];
                    flags_next.dash = 1'b1;
                    phase_next      = flp_pkg::PH_LEAD;
                    acc_next        = '0;
                end
            end
            else if (!flags_reg.extra)
            begin
                unique case (head.item.cls)
                    flp_pkg::CLS_BLANK:
                    begin
                        if (phase_reg == flp_pkg::PH_PLUS)
                        begin
                            phase_next = flp_pkg::PH_BAD;
                        end
                        else if (phase_reg == flp_pkg::PH_DIGITS)
                        begin
                            phase_next = flp_pkg::PH_TRAIL;
                        end
                    end
                    flp_pkg::CLS_PLUS:
                    begin
                        flags_next.nonspace = 1'b1;
                        phase_next = (phase_reg == flp_pkg::PH_LEAD) ? flp_pkg::PH_PLUS
                                                                     : flp_pkg::PH_BAD;
                    end
                    flp_pkg::CLS_DIGIT:
                    begin
                        flags_next.nonspace = 1'b1;
                        if ((phase_reg == flp_pkg::PH_LEAD) || (phase_reg == flp_pkg::PH_PLUS)
                            || (phase_reg == flp_pkg::PH_DIGITS))
                        begin
                            // saturate one past the largest legal value
                            if (acc_reg[VB] || (wide > WIDE_SAT))
                            begin
                                acc_next = ACC_SAT;
                            end
                            else
                            begin
                                acc_next = wide[VB:0];
                            end
                            phase_next = flp_pkg::PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = flp_pkg::PH_BAD;
                        end
                    end
                    default:
                    begin
                        flags_next.nonspace = 1'b1;
                        phase_next = flp_pkg::PH_BAD;
                    end
                endcase
            end
        end

        // end-of-list step works on the state left by the character step
        cl_end = close_token(phase_next, acc_next, first_next, flags_next, terr_next,
                             prev_next, have_prev_next);
        if (head.item.last)
        begin
            if (!nonspace_next)
            begin
                status_next = flp_pkg::ST_EMPTY_LIST;
            end
            else
            begin
                if (lerr_next == flp_pkg::ST_PENDING)
                begin
                    if (cl_end.err == flp_pkg::ST_PENDING)
                    begin
                        emit = 1'b1;
                        lo   = cl_end.a;
                        hi   = cl_end.b;
                    end
                    else
                    begin
                        lerr_next = cl_end.err;
                    end
                end
                status_next = (lerr_next != flp_pkg::ST_PENDING) ? lerr_next
                                                                  : flp_pkg::ST_OK;
            end
            if (status_next != flp_pkg::ST_OK)
            begin
                emit = 1'b0;
            end
            phase_next     = flp_pkg::PH_LEAD;
            acc_next       = '0;
            first_next     = '0;
            flags_next     = '0;
            terr_next      = flp_pkg::ST_PENDING;
            prev_next      = '0;
            have_prev_next = 1'b0;
            nonspace_next  = 1'b0;
            lerr_next      = flp_pkg::ST_PENDING;
        end

        rv_next        = emit;
        first_out_next = emit ? to_out(lo) : '0;
        final_out_next = emit ? to_out(hi) : '0;
        done_next      = head.item.last;
        out_valid_next = pop || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= flp_pkg::PH_LEAD;
            acc_reg       <= '0;
            first_reg     <= '0;
            flags_reg     <= '0;
            terr_reg      <= flp_pkg::ST_PENDING;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            nonspace_reg  <= 1'b0;
            lerr_reg      <= flp_pkg::ST_PENDING;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg     <= phase_next;
                acc_reg       <= acc_next;
                first_reg     <= first_next;
                flags_reg     <= flags_next;
                terr_reg      <= terr_next;
                prev_reg      <= prev_next;
                have_prev_reg <= have_prev_next;
                nonspace_reg  <= nonspace_next;
                lerr_reg      <= lerr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rv_reg        <= rv_next;
            first_out_reg <= first_out_next;
            final_out_reg <= final_out_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign range_valid = rv_reg;
    assign range_first = first_out_reg;
    assign range_final = final_out_reg;
    assign list_done   = done_reg;
    assign status      = status_reg;

endmodule

// ===== hdl/frame_range_list_parser.sv =====
`timescale 1ns / 1ps
// Frame range list parser: one character of a list such as "1-3, 5, 9-12" per
// input transaction, one result transaction per input transaction.
// Input channel (s_axis): tdata = character, tuser = has_char, tlast = end of list.
// Output channel (m_axis): tdata = {range_final, range_first}, tuser = {status,
// range_valid}, tlast = list_done. status is 0 (pending) except on the tlast result,
// which carries the final verdict (1 ok, 2..9 the first error of the list).
// Path: the front end classifies each accepted character into a 4-entry queue at
// the accepting edge; the back end parses the queue head into the output register
// when it pops that head.
// Throughput: one transaction per cycle while the receiver is ready, with a
// combinational parser step (decimal shift-add by ten and the token close compares).
// Reset (rst_n low, asynchronous) empties the queue, drops any pending result and
// puts the parser at the start of a new list. A list also restarts after every
// end-of-list item.
// Receiver stall: the output register holds its result; the back end stops, the
// queue takes up to 4 more transactions, then s_axis_tready drops.
// Ranges already delivered are to be discarded by the receiver when the final
// status is an error.

module frame_range_list_parser
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] ch
    input  logic [0:0]   s_axis_tuser,   // [0] has_char
    input  logic         s_axis_tlast,   // end_of_list

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // [31:0] range_first, [63:32] range_final
    output logic [4:0]   m_axis_tuser,   // [0] range_valid, [4:1] status
    output logic         m_axis_tlast    // list_done
);

    logic                          q_full;
    logic                          push;
    flp_pkg::item_t                push_item;
    logic                          pop;
    flp_pkg::q_head_t              head;
    logic                          range_valid;
    logic [flp_pkg::OUT_W-1:0]     range_first;
    logic [flp_pkg::OUT_W-1:0]     range_final;
    logic [flp_pkg::STATUS_W-1:0]  status;

    flp_front u_front
    (
        .tvalid    (s_axis_tvalid),
        .tready    (s_axis_tready),
        .ch        (s_axis_tdata),
        .has_char  (s_axis_tuser[0]),
        .last      (s_axis_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    flp_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .head      (head)
    );

    flp_back
    #(
        .VALUE_BITS (VALUE_BITS)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .range_valid (range_valid),
        .range_first (range_first),
        .range_final (range_final),
        .list_done   (m_axis_tlast),
        .status      (status)
    );

    assign m_axis_tdata = {range_final, range_first};
    assign m_axis_tuser = {status, range_valid};

`include "frame_range_list_parser_assert.svh"

    // a range only travels with a pending or ok status
    `FLP_ASSERT_NOW(a_range_status, m_axis_tvalid && range_valid, status == flp_pkg::ST_PENDING || status == flp_pkg::ST_OK, "range with error status")
    // only the end-of-list result carries a verdict
    `FLP_ASSERT_NOW(a_pending_mid, m_axis_tvalid && !m_axis_tlast, status == flp_pkg::ST_PENDING, "verdict before end of list")
    // an end item taken by the back end shows up as the next result
    `FLP_ASSERT_NEXT(a_end_result, pop && head.item.last, m_axis_tvalid && m_axis_tlast, "end item lost")
    // with an empty queue the input side must be open
    `FLP_ASSERT_NOW(a_ready_empty, !head.valid, s_axis_tready, "input blocked with empty queue")

endmodule
